@@ rtl/assert_macros.svh @@
// Assertion macros shared by the link readiness sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lrcs_pkg.sv @@
// Types and constants for the link readiness command sequencer.
// No dependencies; used by lrcs_csr, lrcs_state and the top level.
`default_nettype none

package lrcs_pkg;

   // event codes
   localparam logic [3:0] EV_LINK_UP      = 4'd0;
   localparam logic [3:0] EV_LINK_DOWN    = 4'd1;
   localparam logic [3:0] EV_TIME_OK      = 4'd2;
   localparam logic [3:0] EV_TIME_FAIL    = 4'd3;
   localparam logic [3:0] EV_CONFIRM_OK   = 4'd4;
   localparam logic [3:0] EV_CONFIRM_FAIL = 4'd5;
   localparam logic [3:0] EV_SEND_OK      = 4'd8;
   localparam logic [3:0] EV_SEND_FAIL    = 4'd9;

   // func selector
   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_POLL  = 1'b1;

   // command codes
   localparam logic [1:0] CMD_RESYNC = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_SEND   = 2'd2;

   // register map (word index)
   localparam int         CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_RESYNC    = 2'd0;
   localparam logic [1:0] REG_UPDATE    = 2'd1;
   localparam logic [1:0] REG_SENSOR    = 2'd2;

   localparam logic [31:0] RESYNC_PERIOD_RST = 32'd30000;
   localparam logic [31:0] UPDATE_PERIOD_RST = 32'd10000;
   localparam logic [31:0] SENSOR_PERIOD_RST = 32'd5000;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 32;

   typedef struct packed {
      logic        func;
      logic [3:0]  event_code;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [31:0] resync_period_ms;
      logic [31:0] update_period_ms;
      logic [31:0] send_period_ms;
   } period_type;

   typedef struct packed {
      logic        issue;
      logic [1:0]  command;
      logic [31:0] issue_time_ms;
   } decision_type;

endpackage

`default_nettype wire

@@ rtl/link_readiness_command_sequencer.sv @@
// Link readiness command sequencer: request input register, decision
// logic, result register. Depends on lrcs_pkg, lrcs_csr, lrcs_state, assert_macros.svh.
//
// Usage:
//   req channel carries event items (tuser = 0, tdata[3:0] = event code)
//   and poll items (tuser = 1, tdata[35:4] = current time in ms).
//   rsp channel returns at most one command per poll item: tuser holds the
//   command (0 resync, 1 update tick, 2 sensor send), tdata the poll time.
//   csr port holds three period registers at byte offsets 0, 4 and 8.
// Timing:
//   An item is taken into the input register on its transfer; once the result
//   register can move, the flags and timestamps are updated and the result
//   register is loaded. One item per cycle is sustained while rsp is not
//   stalled; the flag update and three wrapping compares are all
//   combinational between the two registers.
// Reset clears all flags, timestamps and both stages, and loads the
// default periods (30000, 10000, 5000 ms).
// A stalled rsp holds its result; the input register takes items while it
// is empty or the result register can move, so req_tready drops after one
// further item is held.
`default_nettype none

`include "assert_macros.svh"

module link_readiness_command_sequencer #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [3:0] event_code, [35:4] now_ms, [39:36] zero
   input  wire logic [lrcs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] func
   input  wire logic [0:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [31:0] issue_time_ms
   output logic [lrcs_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // [1:0] command
   output logic [1:0]                               rsp_tuser,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lrcs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   lrcs_pkg::period_type   periods;
   lrcs_pkg::decision_type decision;
   lrcs_pkg::item_type     in_item_ff;
   logic                   in_valid_ff, in_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_cmd_ff;
   logic [31:0]            rsp_time_ff;
   logic                   out_free;
   logic                   advance;
   logic                   req_xfer;

   lrcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .periods (periods)
   );

   lrcs_state #(
      .TIME_BITS (TIME_BITS)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .periods  (periods),
      .decision (decision)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tdata  = rsp_time_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = decision.issue;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.func       <= req_tuser[0];
         in_item_ff.event_code <= req_tdata[3:0];
         in_item_ff.now_ms     <= req_tdata[35:4];
      end
      if (advance && decision.issue) begin
         rsp_cmd_ff  <= decision.command;
         rsp_time_ff <= decision.issue_time_ms;
      end
   end

   `ASSERT_NEXT(a_in_held_on_stall, clock, reset, in_valid_ff && !advance, in_valid_ff, "held request lost")
   `ASSERT_NEXT(a_event_no_result, clock, reset, advance && in_item_ff.func == lrcs_pkg::FUNC_EVENT, !rsp_valid_ff, "event item produced a result")
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !in_valid_ff, req_tready, "input stage empty but not ready")
   `ASSERT_IMPLY(a_cmd_code_valid, clock, reset, rsp_valid_ff, rsp_cmd_ff != 2'd3, "unused command code")

endmodule

`default_nettype wire

@@ rtl/lrcs_csr.sv @@
// Configuration registers (three period registers) behind an APB-style port.
// Depends on lrcs_pkg.
`default_nettype none

module lrcs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [lrcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready,
   output lrcs_pkg::period_type                   periods
);

   lrcs_pkg::period_type regs_ff, regs_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];
   assign periods = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         case (reg_idx)
            lrcs_pkg::REG_RESYNC: regs_in.resync_period_ms = pwdata;
            lrcs_pkg::REG_UPDATE: regs_in.update_period_ms = pwdata;
            lrcs_pkg::REG_SENSOR: regs_in.send_period_ms   = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lrcs_pkg::REG_RESYNC: prdata = regs_ff.resync_period_ms;
         lrcs_pkg::REG_UPDATE: prdata = regs_ff.update_period_ms;
         lrcs_pkg::REG_SENSOR: prdata = regs_ff.send_period_ms;
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.resync_period_ms <= lrcs_pkg::RESYNC_PERIOD_RST;
         regs_ff.update_period_ms <= lrcs_pkg::UPDATE_PERIOD_RST;
         regs_ff.send_period_ms   <= lrcs_pkg::SENSOR_PERIOD_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lrcs_state.sv @@
// Readiness flags, last-issue timestamps and the command decision.
// Depends on lrcs_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module lrcs_state #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire lrcs_pkg::item_type     item,
   input  wire lrcs_pkg::period_type   periods,
   output lrcs_pkg::decision_type      decision
);

   localparam int CmpBits = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 link_up_ff, link_up_in;
   logic                 time_valid_ff, time_valid_in;
   logic                 upd_conf_ff, upd_conf_in;
   logic                 send_busy_ff, send_busy_in;
   logic [TIME_BITS-1:0] last_resync_ff, last_resync_in;
   logic [TIME_BITS-1:0] last_update_ff, last_update_in;
   logic [TIME_BITS-1:0] last_send_ff, last_send_in;

   logic [TIME_BITS-1:0] now_t;
   logic [CmpBits-1:0]   gap_resync, gap_update, gap_send;
   logic                 due_resync, due_update, due_send;

   // elapsed time wraps at TIME_BITS, compare at the wider of both widths
   always_comb begin
      now_t      = TIME_BITS'(item.now_ms);
      gap_resync = CmpBits'(TIME_BITS'(now_t - last_resync_ff));
      gap_update = CmpBits'(TIME_BITS'(now_t - last_update_ff));
      gap_send   = CmpBits'(TIME_BITS'(now_t - last_send_ff));
      due_resync = gap_resync >= CmpBits'(periods.resync_period_ms);
      due_update = gap_update >= CmpBits'(periods.update_period_ms);
      due_send   = gap_send >= CmpBits'(periods.send_period_ms);
   end

   always_comb begin
      decision.issue         = 1'b0;
      decision.command       = lrcs_pkg::CMD_RESYNC;
      decision.issue_time_ms = 32'(now_t);
      if (item.func == lrcs_pkg::FUNC_POLL && link_up_ff) begin
         if (!time_valid_ff) begin
            decision.issue   = due_resync;
            decision.command = lrcs_pkg::CMD_RESYNC;
         end else if (!upd_conf_ff) begin
            decision.issue   = due_update;
            decision.command = lrcs_pkg::CMD_UPDATE;
         end else begin
            decision.issue   = due_send && !send_busy_ff;
            decision.command = lrcs_pkg::CMD_SEND;
         end
      end
   end

   always_comb begin
      link_up_in     = link_up_ff;
      time_valid_in  = time_valid_ff;
      upd_conf_in    = upd_conf_ff;
      send_busy_in   = send_busy_ff;
      last_resync_in = last_resync_ff;
      last_update_in = last_update_ff;
      last_send_in   = last_send_ff;
      if (step) begin
         if (item.func == lrcs_pkg::FUNC_EVENT) begin
            case (item.event_code)
               lrcs_pkg::EV_LINK_UP:      link_up_in = 1'b1;
               lrcs_pkg::EV_LINK_DOWN: begin
                  link_up_in    = 1'b0;
                  time_valid_in = 1'b0;
                  upd_conf_in   = 1'b0;
                  send_busy_in  = 1'b0;
               end
               lrcs_pkg::EV_TIME_OK:      time_valid_in = 1'b1;
               lrcs_pkg::EV_TIME_FAIL:    time_valid_in = 1'b0;
               lrcs_pkg::EV_CONFIRM_OK:   upd_conf_in   = 1'b1;
               lrcs_pkg::EV_CONFIRM_FAIL: upd_conf_in   = 1'b0;
               lrcs_pkg::EV_SEND_OK,
               lrcs_pkg::EV_SEND_FAIL:    send_busy_in  = 1'b0;
               default: ;
            endcase
         end else if (decision.issue) begin
            case (decision.command)
               lrcs_pkg::CMD_RESYNC: last_resync_in = now_t;
               lrcs_pkg::CMD_UPDATE: last_update_in = now_t;
               lrcs_pkg::CMD_SEND: begin
                  last_send_in = now_t;
                  send_busy_in = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff     <= 1'b0;
         time_valid_ff  <= 1'b0;
         upd_conf_ff    <= 1'b0;
         send_busy_ff   <= 1'b0;
         last_resync_ff <= '0;
         last_update_ff <= '0;
         last_send_ff   <= '0;
      end else begin
         link_up_ff     <= link_up_in;
         time_valid_ff  <= time_valid_in;
         upd_conf_ff    <= upd_conf_in;
         send_busy_ff   <= send_busy_in;
         last_resync_ff <= last_resync_in;
         last_update_ff <= last_update_in;
         last_send_ff   <= last_send_in;
      end
   end

   `ASSERT_IMPLY(a_no_send_when_busy, clock, reset, decision.issue && send_busy_ff, decision.command != lrcs_pkg::CMD_SEND, "send issued while busy")
   `ASSERT_IMPLY(a_no_issue_link_down, clock, reset, !link_up_ff, !decision.issue, "command issued with link down")
   `ASSERT_NEXT(a_send_sets_busy, clock, reset, step && decision.issue && decision.command == lrcs_pkg::CMD_SEND, send_busy_ff, "send did not mark busy")

endmodule

`default_nettype wire

@@ verif/tb_link_readiness_command_sequencer.sv @@
// Self-checking testbench for link_readiness_command_sequencer.
// Holds a cycle-free predictor of flags, timestamps and periods; needs lrcs_pkg and the RTL.
`timescale 1ns / 100ps

module tb_link_readiness_command_sequencer;

   localparam logic [3:0] EV_RUN_OK   = 4'd6;
   localparam logic [3:0] EV_RUN_FAIL = 4'd7;
   localparam int         IDLE_LIMIT  = 5000;
   localparam int         DRAIN_WAIT  = 6;
   localparam int         MAX_PRINTS  = 40;

   typedef struct {
      logic [1:0]  command;
      logic [31:0] issue_time_ms;
   } cmd_issue_type;

   logic clock;
   logic reset;
   logic req_tvalid, req_tready;
   logic [lrcs_pkg::REQ_DATA_BITS-1:0] req_tdata;   // [3:0] event_code, [35:4] now_ms, [39:36] zero
   logic [0:0] req_tuser;                           // [0] func
   logic rsp_tvalid, rsp_tready;
   logic [lrcs_pkg::RSP_DATA_BITS-1:0] rsp_tdata;   // [31:0] issue_time_ms
   logic [1:0] rsp_tuser;                           // [1:0] command
   logic csr_psel, csr_penable, csr_pwrite;
   logic [lrcs_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   link_readiness_command_sequencer DUT (.*);

   // predictor state
   logic lk_up, t_valid, upd_conf, snd_busy;
   logic [31:0] stamp_resync, stamp_update, stamp_send;
   logic [31:0] periods [3];
   cmd_issue_type commands_due[$];

   int mismatches, n_items, n_polls, n_cmds, n_writes;
   int idle_pct, stall_pct, quiet_cycles;
   logic [31:0] cur_ms;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic period_elapsed(input logic [31:0] now, input logic [31:0] last,
                                           input logic [31:0] period);
      logic [31:0] gap;
      gap = now - last;
      return gap >= period;
   endfunction

   // Applies one accepted item to the predicted state, queueing any command it issues.
   task automatic step_readiness(input lrcs_pkg::item_type it);
      cmd_issue_type c;
      c.issue_time_ms = it.now_ms;
      c.command = lrcs_pkg::CMD_RESYNC;
      if (it.func == lrcs_pkg::FUNC_EVENT) begin
         case (it.event_code)
            lrcs_pkg::EV_LINK_UP: lk_up = 1'b1;
            lrcs_pkg::EV_LINK_DOWN: begin
               lk_up = 1'b0;
               t_valid = 1'b0;
               upd_conf = 1'b0;
               snd_busy = 1'b0;
            end
            lrcs_pkg::EV_TIME_OK: t_valid = 1'b1;
            lrcs_pkg::EV_TIME_FAIL: t_valid = 1'b0;
            lrcs_pkg::EV_CONFIRM_OK: upd_conf = 1'b1;
            lrcs_pkg::EV_CONFIRM_FAIL: upd_conf = 1'b0;
            lrcs_pkg::EV_SEND_OK, lrcs_pkg::EV_SEND_FAIL: snd_busy = 1'b0;
            default: ;
         endcase
      end else if (lk_up) begin
         if (!t_valid) begin
            if (period_elapsed(it.now_ms, stamp_resync, periods[lrcs_pkg::REG_RESYNC])) begin
               stamp_resync = it.now_ms;
               c.command = lrcs_pkg::CMD_RESYNC;
               commands_due.push_back(c);
            end
         end else if (!upd_conf) begin
            if (period_elapsed(it.now_ms, stamp_update, periods[lrcs_pkg::REG_UPDATE])) begin
               stamp_update = it.now_ms;
               c.command = lrcs_pkg::CMD_UPDATE;
               commands_due.push_back(c);
            end
         end else if (!snd_busy &&
                      period_elapsed(it.now_ms, stamp_send,
                                     periods[lrcs_pkg::REG_SENSOR])) begin
            stamp_send = it.now_ms;
            snd_busy = 1'b1;
            c.command = lrcs_pkg::CMD_SEND;
            commands_due.push_back(c);
         end
      end
   endtask

   // Checks results and feeds the predictor, both on transfers seen at the rising edge.
   always @(posedge clock) begin : monitor
      cmd_issue_type want;
      lrcs_pkg::item_type it;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_cmds++;
            if (commands_due.size() == 0) begin
               report_mismatch("unexpected command", {30'd0, rsp_tuser}, 32'd0);
            end else begin
               want = commands_due.pop_front();
               if (rsp_tuser !== want.command)
                  report_mismatch("command", {30'd0, rsp_tuser}, {30'd0, want.command});
               if (rsp_tdata !== want.issue_time_ms)
                  report_mismatch("issue_time_ms", rsp_tdata, want.issue_time_ms);
            end
         end
         if (req_tvalid && req_tready) begin
            it.func = req_tuser[0];
            it.event_code = req_tdata[3:0];
            it.now_ms = req_tdata[35:4];
            n_items++;
            if (it.func == lrcs_pkg::FUNC_POLL) n_polls++;
            step_readiness(it);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d commands outstanding",
                  IDLE_LIMIT, commands_due.size());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // Drives one item and returns right after the edge that takes it.
   task automatic send_item(input logic func, input logic [3:0] code, input logic [31:0] now);
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {4'b0000, now, code};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic poll(input logic [31:0] now);
      send_item(lrcs_pkg::FUNC_POLL, 4'($urandom), now);
   endtask

   task automatic post_event(input logic [3:0] code);
      send_item(lrcs_pkg::FUNC_EVENT, code, $urandom);
   endtask

   // Registers only change while nothing is in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (commands_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_check(input logic [1:0] idx);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== periods[idx])
         report_mismatch($sformatf("register %0d readback", idx), csr_prdata, periods[idx]);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      periods[idx] = value;
      n_writes++;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_pwdata = $urandom;
      csr_check(idx);
   endtask

   task automatic set_periods(input logic [31:0] rp, input logic [31:0] up,
                              input logic [31:0] sp);
      wait_drained();
      csr_write(lrcs_pkg::REG_RESYNC, rp);
      csr_write(lrcs_pkg::REG_UPDATE, up);
      csr_write(lrcs_pkg::REG_SENSOR, sp);
   endtask

   task automatic test_reset_values();
      csr_check(lrcs_pkg::REG_RESYNC);
      csr_check(lrcs_pkg::REG_UPDATE);
      csr_check(lrcs_pkg::REG_SENSOR);
   endtask

   // Walks every event and command with the default periods, edges of each period included.
   task automatic test_directed();
      poll(32'd40000);                  // link not up yet
      post_event(lrcs_pkg::EV_LINK_UP);
      poll(32'd29999);
      poll(32'd30000);
      poll(32'd30001);
      post_event(lrcs_pkg::EV_TIME_OK);
      poll(32'd9999);
      poll(32'd10000);
      post_event(lrcs_pkg::EV_CONFIRM_OK);
      poll(32'd5000);
      poll(32'd20000);                  // send still busy
      post_event(EV_RUN_OK);
      post_event(EV_RUN_FAIL);
      post_event(4'hF);
      poll(32'd20000);
      post_event(lrcs_pkg::EV_SEND_OK);
      poll(32'hFFFF_FFFF);
      post_event(lrcs_pkg::EV_SEND_FAIL);
      post_event(lrcs_pkg::EV_SEND_OK); // nothing busy
      post_event(lrcs_pkg::EV_CONFIRM_FAIL);
      poll(32'd20000);
      post_event(lrcs_pkg::EV_TIME_FAIL);
      poll(32'd60000);
      post_event(lrcs_pkg::EV_LINK_DOWN); // stamps survive
      post_event(lrcs_pkg::EV_LINK_UP);
      poll(32'd90000);
   endtask

   task automatic test_period_extremes();
      logic [31:0] t;
      set_periods(32'd0, 32'd0, 32'd0);
      t = $urandom;
      poll(t);
      poll(t);
      post_event(lrcs_pkg::EV_TIME_OK);
      poll(t);
      post_event(lrcs_pkg::EV_CONFIRM_OK);
      poll(t);
      poll(t);
      post_event(lrcs_pkg::EV_SEND_OK);
      poll(t);
      set_periods(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      post_event(lrcs_pkg::EV_SEND_OK);
      poll(stamp_send - 32'd2);
      poll(stamp_send - 32'd1);         // gap equals the full period
      wait_drained();
      post_event(lrcs_pkg::EV_TIME_FAIL);
      poll(stamp_resync - 32'd2);
      poll(stamp_resync - 32'd1);
   endtask

   // Mostly sequences that move the flags forward, with some that knock them back.
   function automatic logic [3:0] pick_event();
      int r;
      r = $urandom_range(99, 0);
      if (r < 3) return lrcs_pkg::EV_LINK_DOWN;
      if (r < 6) return (r[0] ? EV_RUN_OK : EV_RUN_FAIL);
      if (r < 9) return 4'(lrcs_pkg::EV_SEND_FAIL + $urandom_range(6, 1));
      if (r < 13) return lrcs_pkg::EV_TIME_FAIL;
      if (r < 17) return lrcs_pkg::EV_CONFIRM_FAIL;
      if (!lk_up) return lrcs_pkg::EV_LINK_UP;
      if (!t_valid) return (r < 60 ? lrcs_pkg::EV_TIME_OK : lrcs_pkg::EV_LINK_UP);
      if (!upd_conf) return (r < 60 ? lrcs_pkg::EV_CONFIRM_OK : lrcs_pkg::EV_LINK_UP);
      if (r < 60) return lrcs_pkg::EV_SEND_OK;
      if (r < 75) return lrcs_pkg::EV_SEND_FAIL;
      return lrcs_pkg::EV_LINK_UP;
   endfunction

   task automatic random_item(input int step_max);
      int r;
      logic [31:0] stamp;
      r = $urandom_range(99, 0);
      if (r < 55) begin
         r = $urandom_range(99, 0);
         stamp = !t_valid ? stamp_resync : (!upd_conf ? stamp_update : stamp_send);
         if (r < 4) cur_ms = $urandom;
         else if (r < 9) cur_ms = stamp - 32'd1;
         else cur_ms += 32'($urandom_range(step_max, 0));
         poll(cur_ms);
      end else begin
         post_event(pick_event());
      end
   endtask

   task automatic run_phase(input int n, input logic [31:0] rp, input logic [31:0] up,
                            input logic [31:0] sp, input int step_max, input int idle,
                            input logic [31:0] start_ms);
      set_periods(rp, up, sp);
      idle_pct = idle;
      stall_pct = idle;
      cur_ms = start_ms;
      repeat (n) random_item(step_max);
   endtask

   task automatic test_random();
      run_phase(200, lrcs_pkg::RESYNC_PERIOD_RST, lrcs_pkg::UPDATE_PERIOD_RST,
                lrcs_pkg::SENSOR_PERIOD_RST, 4000, 11, stamp_send);
      run_phase(200, $urandom_range(300, 0), $urandom_range(300, 0), $urandom_range(300, 0),
                150, 0, 32'hFFFF_F000);
      run_phase(200, 32'd0, 32'd0, 32'd0, 3, 11, $urandom);
      run_phase(200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1000, 11, $urandom);
      run_phase(200, $urandom, $urandom, $urandom, 32'h7FFF_FFFF, 11, $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = lrcs_pkg::FUNC_EVENT;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      lk_up = 1'b0;
      t_valid = 1'b0;
      upd_conf = 1'b0;
      snd_busy = 1'b0;
      stamp_resync = '0;
      stamp_update = '0;
      stamp_send = '0;
      periods[lrcs_pkg::REG_RESYNC] = lrcs_pkg::RESYNC_PERIOD_RST;
      periods[lrcs_pkg::REG_UPDATE] = lrcs_pkg::UPDATE_PERIOD_RST;
      periods[lrcs_pkg::REG_SENSOR] = lrcs_pkg::SENSOR_PERIOD_RST;
      mismatches = 0;
      n_items = 0;
      n_polls = 0;
      n_cmds = 0;
      n_writes = 0;
      idle_pct = 11;
      stall_pct = 11;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_directed();
      test_period_extremes();
      test_random();
      wait_drained();

      $display("Covered %0d request transfers (%0d polls), %0d commands checked,",
               n_items, n_polls, n_cmds);
      $display("%0d period register writes including zero and all-ones periods.", n_writes);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
